// ===== sv/slcfp_pkg.sv =====
package slcfp_pkg;

  // sizes
  localparam int MAX_VALUES = 32;
  localparam int ADDR_W     = $clog2(MAX_VALUES);
  localparam int FILL_W     = $clog2(MAX_VALUES + 1);
  localparam int BYTE_W     = 8;
  localparam int VIDX_W     = 5;
  localparam int OUT_DATA_W = 64;

  // register reset values
  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] END_RESET  = 8'h00;

  // configuration register indexes
  localparam logic CFG_SYNC = 1'b0;
  localparam logic CFG_END  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_LENGTH   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_HUNT     = 4'd0,
    PH_LENGTH   = 4'd1,
    PH_REQUEST  = 4'd2,
    PH_DEVICE   = 4'd3,
    PH_COMMAND  = 4'd4,
    PH_REGISTER = 4'd5,
    PH_TYPE     = 4'd6,
    PH_VALUES   = 4'd7,
    PH_CHECKSUM = 4'd8,
    PH_STOP     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_SHOW = 2'd2
  } emit_state_t;

  // held frame header shared by parser and emitter
  typedef struct packed {
    byte_t length;
    byte_t request;
    byte_t device;
    byte_t command;
    byte_t reg_num;
    byte_t vtype;
  } header_t;

  // request from parser to start a run of results
  typedef struct packed {
    logic    go;
    logic    with_values;
    status_t status;
  } run_req_t;

endpackage

// ===== sv/slcfp_ram.sv =====
module slcfp_ram
  import slcfp_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  byte_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output byte_t             rd_data
);

  byte_t mem [MAX_VALUES];
  byte_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/slcfp_parser.sv =====
module slcfp_parser
  import slcfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  byte_t             cfg_wdata,
  input  logic              accept,
  input  byte_t             rx_byte,
  output header_t           hdr,
  output run_req_t          run_req,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output byte_t             wr_data
);

  phase_t              phase_r, phase_nxt;
  byte_t               sum_r, sum_nxt;
  header_t             hdr_r, hdr_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FILL_W-1:0]   fill_inc;
  byte_t               sync_r, end_r;
  logic                too_long;
  logic                fill_done;
  logic                sum_ok;

  assign fill_inc  = fill_r + FILL_W'(1);
  assign fill_done = BYTE_W'(fill_inc) >= hdr_r.length;
  assign too_long  = rx_byte > BYTE_W'(MAX_VALUES);
  assign sum_ok    = sum_r == rx_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      end_r  <= END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC: sync_r <= cfg_wdata;
        CFG_END:  end_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_LENGTH:   phase_nxt = too_long ? PH_HUNT : PH_REQUEST;
        PH_REQUEST:  phase_nxt = PH_DEVICE;
        PH_DEVICE:   phase_nxt = PH_COMMAND;
        PH_COMMAND:  phase_nxt = PH_REGISTER;
        PH_REGISTER: phase_nxt = (hdr_r.length != '0) ? PH_TYPE : PH_CHECKSUM;
        PH_TYPE:     phase_nxt = PH_VALUES;
        PH_VALUES:   phase_nxt = fill_done ? PH_CHECKSUM : PH_VALUES;
        PH_CHECKSUM: phase_nxt = sum_ok ? PH_STOP : PH_HUNT;
        PH_STOP:     phase_nxt = (rx_byte == end_r) ? PH_HUNT : PH_STOP;
        default:     phase_nxt = (rx_byte == sync_r) ? PH_LENGTH : PH_HUNT;
      endcase
    end
  end

  // held fields, running sum, store writes and run requests
  always_comb begin
    sum_nxt             = sum_r;
    hdr_nxt             = hdr_r;
    fill_nxt            = fill_r;
    wr_en               = 1'b0;
    run_req.go          = 1'b0;
    run_req.with_values = 1'b0;
    run_req.status      = ST_DATA;
    if (accept) begin
      if (phase_r >= PH_LENGTH && phase_r <= PH_VALUES) begin
        sum_nxt = sum_r + rx_byte;
      end
      unique case (phase_r)
        PH_LENGTH: begin
          // too long: length goes out with an all-zero header
          hdr_nxt.length = rx_byte;
          if (too_long) begin
            run_req.go     = 1'b1;
            run_req.status = ST_LENGTH;
          end
        end
        PH_REQUEST:  hdr_nxt.request = rx_byte;
        PH_DEVICE:   hdr_nxt.device  = rx_byte;
        PH_COMMAND:  hdr_nxt.command = rx_byte;
        PH_REGISTER: hdr_nxt.reg_num = rx_byte;
        PH_TYPE:     hdr_nxt.vtype   = rx_byte;
        PH_VALUES: begin
          wr_en    = 1'b1;
          fill_nxt = fill_done ? '0 : fill_inc;
        end
        PH_CHECKSUM: begin
          if (!sum_ok) begin
            run_req.go     = 1'b1;
            run_req.status = ST_CHECKSUM;
          end
        end
        PH_STOP: begin
          if (rx_byte == end_r) begin
            run_req.go          = 1'b1;
            run_req.with_values = hdr_r.length != '0;
          end
        end
        default: begin
          if (rx_byte == sync_r) begin
            sum_nxt  = '0;
            hdr_nxt  = '0;
            fill_nxt = '0;
          end
        end
      endcase
    end
  end

  assign wr_addr = fill_r[ADDR_W-1:0];
  assign wr_data = rx_byte;
  assign hdr     = hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= '0;
      hdr_r   <= '0;
      fill_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      hdr_r   <= hdr_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

// ===== sv/slcfp_emit.sv =====
module slcfp_emit
  import slcfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  run_req_t          run_req,
  input  header_t           hdr,
  input  byte_t             rd_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output logic              busy,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic              out_tlast
);

  emit_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              values_r, values_nxt;
  status_t           status_r, status_nxt;
  logic              is_last;
  byte_t             value_byte;
  logic [VIDX_W-1:0] value_index;

  assign is_last = values_r ? ((BYTE_W'(idx_r) + BYTE_W'(1)) == hdr.length) : 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EM_IDLE: begin
        if (run_req.go) begin
          state_nxt = run_req.with_values ? EM_READ : EM_SHOW;
        end
      end
      EM_READ: state_nxt = EM_SHOW;
      EM_SHOW: begin
        if (out_tready) begin
          state_nxt = is_last ? EM_IDLE : EM_READ;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  // run bookkeeping
  always_comb begin
    idx_nxt    = idx_r;
    values_nxt = values_r;
    status_nxt = status_r;
    if (state_r == EM_IDLE && run_req.go) begin
      idx_nxt    = '0;
      values_nxt = run_req.with_values;
      status_nxt = run_req.status;
    end else if (state_r == EM_SHOW && out_tready && !is_last) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  // outputs
  always_comb begin
    rd_en       = state_r == EM_READ;
    rd_addr     = idx_r;
    busy        = state_r != EM_IDLE;
    out_tvalid  = state_r == EM_SHOW;
    value_byte  = values_r ? rd_data : '0;
    value_index = values_r ? VIDX_W'(idx_r) : '0;
  end

  assign out_tdata = {1'b0, value_byte, value_index, hdr.vtype, hdr.reg_num,
                      hdr.command, hdr.device, hdr.request, hdr.length, status_r};
  assign out_tlast = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= EM_IDLE;
      idx_r    <= '0;
      values_r <= 1'b0;
      status_r <= ST_DATA;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      values_r <= values_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== sv/sync_length_checksum_frame_parser_top.sv =====
// channel  direction  payload
// in_      input      tdata[7:0] rx_byte
// out_     output     tdata: status, length, request, device, command, register,
//                     value type, value index, value byte; tlast marks end of run
// cfg_     input      write: index 0 sync pattern, index 1 end pattern
//
// one received byte per cycle while no run of results is being sent
// each value result is read from the value store, then shown on the output
// a header-only or error result is shown the cycle after the byte that releases it
// input stalls from the cycle after the byte that starts a run until the cycle
// after its last result is taken
// synchronous active-low reset; sync 0x55, end 0x00, parser hunting for sync
module sync_length_checksum_frame_parser_top
  import slcfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [9:2] frame_length, [17:10] request_id, [25:18] device_id,
  // [33:26] command_code, [41:34] register_number, [49:42] value_type,
  // [54:50] value_index, [62:55] value_byte, [63] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_wdata
);

  header_t           hdr;
  run_req_t          run_req;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  byte_t             wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  byte_t             rd_data;
  logic              busy;
  logic              accept;

  assign in_tready = !busy;
  assign accept    = in_tvalid && in_tready;

  // byte parser and held header
  slcfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (in_tdata),
    .hdr       (hdr),
    .run_req   (run_req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // value store
  slcfp_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result sequencer
  slcfp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .run_req    (run_req),
    .hdr        (hdr),
    .rd_data    (rd_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import slcfp_pkg::*;

  // one expected or observed result transaction
  typedef struct {
    status_t           status;
    byte_t             length;
    byte_t             request;
    byte_t             device;
    byte_t             command;
    byte_t             reg_num;
    byte_t             vtype;
    logic [VIDX_W-1:0] index;
    byte_t             value;
    logic              last;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_SYNC;
  logic [BYTE_W-1:0]     cfg_wdata = '0;

  sync_length_checksum_frame_parser_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent and results waiting to arrive
  byte_t         rx_bytes_q[$];
  frame_result_t frame_results_q[$];

  // parser shadow: registers and frame state
  byte_t       sync_pat = SYNC_RESET;
  byte_t       end_pat = END_RESET;
  phase_t      ph = PH_HUNT;
  byte_t       run_sum = '0;
  byte_t       h_len = '0;
  byte_t       h_req = '0;
  byte_t       h_dev = '0;
  byte_t       h_cmd = '0;
  byte_t       h_reg = '0;
  byte_t       h_type = '0;
  logic [5:0]  fill = '0;
  byte_t       value_mem[MAX_VALUES];

  bit no_gaps = 1'b0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int settings_run = 1;
  int n_data = 0;
  int n_sum_err = 0;
  int n_len_err = 0;
  int mismatch_count = 0;

  function automatic frame_result_t held_result(status_t st, logic [VIDX_W-1:0] idx,
                                                byte_t val, logic lst);
    frame_result_t r;
    r.status  = st;
    r.length  = h_len;
    r.request = h_req;
    r.device  = h_dev;
    r.command = h_cmd;
    r.reg_num = h_reg;
    r.vtype   = h_type;
    r.index   = idx;
    r.value   = val;
    r.last    = lst;
    return r;
  endfunction

  // advance the frame parser by one received byte, queue the results it releases
  task automatic parse_byte(byte_t b);
    frame_result_t r;
    if (ph >= PH_LENGTH && ph <= PH_VALUES) run_sum = run_sum + b;
    case (ph)
      PH_LENGTH: begin
        if (b > MAX_VALUES) begin
          // header fields are still clear right after sync
          r = held_result(ST_LENGTH, '0, '0, 1'b1);
          r.length = b;
          frame_results_q.push_back(r);
          ph = PH_HUNT;
        end else begin
          h_len = b;
          ph = PH_REQUEST;
        end
      end
      PH_REQUEST: begin
        h_req = b;
        ph = PH_DEVICE;
      end
      PH_DEVICE: begin
        h_dev = b;
        ph = PH_COMMAND;
      end
      PH_COMMAND: begin
        h_cmd = b;
        ph = PH_REGISTER;
      end
      PH_REGISTER: begin
        h_reg = b;
        ph = (h_len > 0) ? PH_TYPE : PH_CHECKSUM;
      end
      PH_TYPE: begin
        h_type = b;
        ph = PH_VALUES;
      end
      PH_VALUES: begin
        value_mem[fill[ADDR_W-1:0]] = b;
        fill = fill + 6'd1;
        if (fill >= h_len) begin
          fill = '0;
          ph = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        if (run_sum == b) begin
          ph = PH_STOP;
        end else begin
          frame_results_q.push_back(held_result(ST_CHECKSUM, '0, '0, 1'b1));
          ph = PH_HUNT;
        end
      end
      PH_STOP: begin
        if (b == end_pat) begin
          // header-only frame keeps value type zero since it was cleared at sync
          if (h_len == 0) begin
            frame_results_q.push_back(held_result(ST_DATA, '0, '0, 1'b1));
          end else begin
            for (int i = 0; i < h_len; i++)
              frame_results_q.push_back(held_result(ST_DATA, i[VIDX_W-1:0], value_mem[i],
                                                    (i + 1 == h_len)));
          end
          ph = PH_HUNT;
        end
      end
      default: begin
        ph = PH_HUNT;
        if (b == sync_pat) begin
          ph = PH_LENGTH;
          run_sum = '0;
          h_len = '0;
          h_req = '0;
          h_dev = '0;
          h_cmd = '0;
          h_reg = '0;
          h_type = '0;
          fill = '0;
        end
      end
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // compare one result transaction with the oldest expectation
  task automatic check_result();
    frame_result_t e;
    if (frame_results_q.size() == 0) begin
      report("result with nothing expected", out_tdata, 0);
      return;
    end
    e = frame_results_q.pop_front();
    if (out_tdata[1:0] !== e.status)   report("status", out_tdata[1:0], e.status);
    if (out_tdata[9:2] !== e.length)   report("frame_length", out_tdata[9:2], e.length);
    if (out_tdata[17:10] !== e.request) report("request_id", out_tdata[17:10], e.request);
    if (out_tdata[25:18] !== e.device) report("device_id", out_tdata[25:18], e.device);
    if (out_tdata[33:26] !== e.command) report("command_code", out_tdata[33:26], e.command);
    if (out_tdata[41:34] !== e.reg_num) report("register_number", out_tdata[41:34], e.reg_num);
    if (out_tdata[49:42] !== e.vtype)  report("value_type", out_tdata[49:42], e.vtype);
    if (out_tdata[54:50] !== e.index)  report("value_index", out_tdata[54:50], e.index);
    if (out_tdata[62:55] !== e.value)  report("value_byte", out_tdata[62:55], e.value);
    if (out_tlast !== e.last)          report("last", out_tlast, e.last);
    case (e.status)
      ST_CHECKSUM: n_sum_err++;
      ST_LENGTH:   n_len_err++;
      default:     n_data++;
    endcase
  endtask

  // byte driver: holds a transaction until taken, random gaps between unless no_gaps is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (rx_bytes_q.size() != 0 && (no_gaps || $urandom_range(99) >= 11)) begin
          in_tvalid <= 1'b1;
          in_tdata <= rx_bytes_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure unless no_gaps is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      out_tready <= no_gaps || ($urandom_range(99) >= 11);
    end
  end

  task automatic push_byte(byte_t b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  // line noise that cannot start a frame
  task automatic push_noise(int n);
    byte_t v;
    repeat (n) begin
      v = byte_t'($urandom);
      if (v == sync_pat) v = ~v;
      push_byte(v);
    end
  endtask

  // one frame; fill_val < 0 gives random header and values, else those after length are all fill_val
  task automatic push_frame(int len, int fill_val, bit bad_sum, int junk);
    byte_t sum;
    byte_t v;
    push_byte(sync_pat);
    push_byte(len[7:0]);
    if (len > MAX_VALUES) return;
    sum = len[7:0];
    repeat (len > 0 ? len + 5 : 4) begin
      v = (fill_val < 0) ? byte_t'($urandom) : byte_t'(fill_val);
      push_byte(v);
      sum = sum + v;
    end
    push_byte(bad_sum ? byte_t'(sum + $urandom_range(1, 255)) : sum);
    // bytes other than the stop pattern are dropped while waiting for it
    repeat (junk) begin
      v = byte_t'($urandom);
      if (v == end_pat) v = ~v;
      push_byte(v);
    end
    push_byte(end_pat);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_taken != bytes_queued || frame_results_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, byte_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SYNC) sync_pat = val;
    else end_pat = val;
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic random_frames(int nbytes);
    int target;
    int kind;
    int len;
    target = bytes_queued + nbytes;
    while (bytes_queued < target) begin
      kind = $urandom_range(99);
      len = ($urandom_range(99) < 8) ? $urandom_range(24, MAX_VALUES) : $urandom_range(0, 6);
      if (kind < 70)      push_frame(len, -1, 1'b0, 0);
      else if (kind < 80) push_frame(len, -1, 1'b1, 0);
      else if (kind < 87) push_frame($urandom_range(MAX_VALUES + 1, 255), -1, 1'b0, 0);
      else if (kind < 95) push_frame(len, -1, 1'b0, $urandom_range(1, 4));
      else                push_noise($urandom_range(1, 5));
    end
  endtask

  task automatic run_setting(byte_t sync_val, byte_t end_val, bit steady);
    wait_idle();
    write_reg(CFG_SYNC, sync_val);
    write_reg(CFG_END, end_val);
    no_gaps = steady;
    settings_run++;
    random_frames(100);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under reset patterns
    push_noise(2);
    push_frame(0, 8'h00, 1'b0, 0);          // header-only frame, all zero
    push_frame(1, 8'hFF, 1'b0, 0);          // all ones header after length, type and value
    push_frame(MAX_VALUES + 1, -1, 1'b0, 0); // just over the store size
    push_frame(255, -1, 1'b0, 0);           // largest length byte
    push_frame(2, -1, 1'b1, 0);             // bad checksum
    push_frame(1, -1, 1'b0, 2);             // junk before the stop byte
    random_frames(100);

    run_setting(8'h00, 8'hFF, 1'b0);
    run_setting(8'hFF, 8'h00, 1'b1);
    run_setting(byte_t'($urandom), byte_t'($urandom), 1'b0);
    run_setting(8'hA5, 8'hA5, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("sent %0d bytes under %0d sync/stop register settings", bytes_taken,
             settings_run);
    $display("checked %0d frame data, %0d checksum error, %0d length error results",
             n_data, n_sum_err, n_len_err);
    if (mismatch_count == 0) begin
      $display("** sync_length_checksum_frame_parser_top: PASSED **");
    end else begin
      $display("** sync_length_checksum_frame_parser_top: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", frame_results_q.size());
    $display("** sync_length_checksum_frame_parser_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/slcfp_pkg.sv
sv/slcfp_ram.sv
sv/slcfp_parser.sv
sv/slcfp_emit.sv
sv/sync_length_checksum_frame_parser_top.sv
dv/testbench.sv
